>>> hw/rtl/rtnu_pkg.sv
// Shared types, codes and default sizes for the reload timer with round notify.
`default_nettype none
package rtnu_pkg;

	// Default sizes
	localparam int COUNTER_BITS_DEF = 24;
	localparam int ROUND_BITS_DEF   = 8;
	localparam int DATA_BITS        = 32;

	// Request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	// Register addresses
	localparam logic [1:0] ADDR_CTRL    = 2'd0;
	localparam logic [1:0] ADDR_RELOAD  = 2'd1;
	localparam logic [1:0] ADDR_CURRENT = 2'd2;
	localparam logic [1:0] ADDR_NOTIFY  = 2'd3;

	// Control register bit positions
	localparam int CTRL_EN_BIT     = 0;
	localparam int CTRL_IRQ_BIT    = 1;
	localparam int CTRL_CLKSRC_BIT = 2;
	localparam int CTRL_FLAG_BIT   = 16;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [1:0]           reg_addr;
		logic [DATA_BITS-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [DATA_BITS-1:0] read_data;
		logic                 irq_pulse;
		logic                 notify_pulse;
	} rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/rtnu_if.sv
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface rtnu_req_if;
	import rtnu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic [1:0]           reg_addr;
	logic [DATA_BITS-1:0] write_data;

	modport source (output valid, req_type, reg_addr, write_data, input ready);
	modport sink   (input valid, req_type, reg_addr, write_data, output ready);
endinterface

interface rtnu_rsp_if;
	import rtnu_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [DATA_BITS-1:0] read_data;
	logic                 irq_pulse;
	logic                 notify_pulse;

	modport source (output valid, read_data, irq_pulse, notify_pulse, input ready);
	modport sink   (input valid, read_data, irq_pulse, notify_pulse, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/reload_timer_with_round_notify_unit.sv
// Reload timer with round notify: one request beat in, one response beat out.
// Latency: a response is valid the cycle after its request is accepted.
// Throughput: one request per cycle; a held response stalls intake until taken.
// Reset: arst_n clears all timer state and the response valid; no clearing pass.
`default_nettype none
module reload_timer_with_round_notify_unit
	import rtnu_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF,
	parameter int ROUND_BITS   = ROUND_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rtnu_req_if.sink    req,
	rtnu_rsp_if.source  rsp
);

	req_t req_in;
	rsp_t rsp_next;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic accept;

	assign req_in = '{req_type: req.req_type, reg_addr: req.reg_addr,
		write_data: req.write_data};

	// take a new beat whenever the response register is empty or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	rtnu_core #(
		.COUNTER_BITS(COUNTER_BITS),
		.ROUND_BITS  (ROUND_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (accept),
		.req   (req_in),
		.rsp   (rsp_next)
	);

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.read_data    = rsp_q.read_data;
	assign rsp.irq_pulse    = rsp_q.irq_pulse;
	assign rsp.notify_pulse = rsp_q.notify_pulse;

endmodule
`default_nettype wire

>>> hw/rtl/rtnu_core.sv
// Timer register file, down-counter and round notification logic.
`default_nettype none
module rtnu_core
	import rtnu_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF,
	parameter int ROUND_BITS   = ROUND_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire req_t req,
	output rsp_t      rsp
);

	logic                    run_enable_q, irq_enable_q, clock_select_q, count_flag_q;
	logic [COUNTER_BITS-1:0] reload_value_q, current_value_q;
	logic                    notify_armed_q, notify_periodic_q;
	logic [ROUND_BITS-1:0]   rounds_left_q, rounds_restore_q;

	logic                    run_enable_d, irq_enable_d, clock_select_d, count_flag_d;
	logic [COUNTER_BITS-1:0] reload_value_d, current_value_d;
	logic                    notify_armed_d, notify_periodic_d;
	logic [ROUND_BITS-1:0]   rounds_left_d, rounds_restore_d;

	logic [COUNTER_BITS-1:0] cur_dec;
	logic                    wrap;

	assign cur_dec = current_value_q - COUNTER_BITS'(1);
	// counter passing from one to zero on a running tick
	assign wrap = (req.req_type == REQ_TICK) && run_enable_q
		&& (current_value_q != '0) && (cur_dec == '0);

	// Next state and response for one request
	always_comb begin
		run_enable_d      = run_enable_q;
		irq_enable_d      = irq_enable_q;
		clock_select_d    = clock_select_q;
		count_flag_d      = count_flag_q;
		reload_value_d    = reload_value_q;
		current_value_d   = current_value_q;
		notify_armed_d    = notify_armed_q;
		notify_periodic_d = notify_periodic_q;
		rounds_left_d     = rounds_left_q;
		rounds_restore_d  = rounds_restore_q;
		rsp               = '0;

		case (req.req_type)
			REQ_TICK: begin
				if (run_enable_q) begin
					if (current_value_q == '0) begin
						current_value_d = reload_value_q;
					end else begin
						current_value_d = cur_dec;
					end
				end
				if (wrap) begin
					count_flag_d  = 1'b1;
					rsp.irq_pulse = irq_enable_q;
					if (notify_armed_q) begin
						if (rounds_left_q != '0) begin
							rounds_left_d = rounds_left_q - ROUND_BITS'(1);
						end else begin
							rsp.notify_pulse = 1'b1;
							if (notify_periodic_q) begin
								rounds_left_d = rounds_restore_q;
							end else begin
								reload_value_d  = '0;
								current_value_d = '0;
								notify_armed_d  = 1'b0;
							end
						end
					end
				end
			end
			REQ_READ: begin
				case (req.reg_addr)
					ADDR_CTRL: begin
						rsp.read_data[CTRL_EN_BIT]     = run_enable_q;
						rsp.read_data[CTRL_IRQ_BIT]    = irq_enable_q;
						rsp.read_data[CTRL_CLKSRC_BIT] = clock_select_q;
						rsp.read_data[CTRL_FLAG_BIT]   = count_flag_q;
						count_flag_d = 1'b0;
					end
					ADDR_RELOAD:  rsp.read_data[COUNTER_BITS-1:0] = reload_value_q;
					ADDR_CURRENT: rsp.read_data[COUNTER_BITS-1:0] = current_value_q;
					default: begin
						rsp.read_data[ROUND_BITS-1:0] = rounds_left_q;
						rsp.read_data[ROUND_BITS]     = notify_periodic_q;
						rsp.read_data[ROUND_BITS+1]   = notify_armed_q;
					end
				endcase
			end
			REQ_WRITE: begin
				case (req.reg_addr)
					ADDR_CTRL: begin
						run_enable_d   = req.write_data[CTRL_EN_BIT];
						irq_enable_d   = req.write_data[CTRL_IRQ_BIT];
						clock_select_d = req.write_data[CTRL_CLKSRC_BIT];
					end
					ADDR_RELOAD: reload_value_d = req.write_data[COUNTER_BITS-1:0];
					ADDR_CURRENT: begin
						// any write clears the counter and the flag
						current_value_d = '0;
						count_flag_d    = 1'b0;
					end
					default: begin
						rounds_left_d     = req.write_data[ROUND_BITS-1:0];
						rounds_restore_d  = req.write_data[ROUND_BITS-1:0];
						notify_periodic_d = req.write_data[ROUND_BITS];
						notify_armed_d    = req.write_data[ROUND_BITS+1];
					end
				endcase
			end
			default: ;
		endcase
	end

	// State registers, updated on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_enable_q      <= 1'b0;
			irq_enable_q      <= 1'b0;
			clock_select_q    <= 1'b0;
			count_flag_q      <= 1'b0;
			reload_value_q    <= '0;
			current_value_q   <= '0;
			notify_armed_q    <= 1'b0;
			notify_periodic_q <= 1'b0;
			rounds_left_q     <= '0;
			rounds_restore_q  <= '0;
		end else if (step) begin
			run_enable_q      <= run_enable_d;
			irq_enable_q      <= irq_enable_d;
			clock_select_q    <= clock_select_d;
			count_flag_q      <= count_flag_d;
			reload_value_q    <= reload_value_d;
			current_value_q   <= current_value_d;
			notify_armed_q    <= notify_armed_d;
			notify_periodic_q <= notify_periodic_d;
			rounds_left_q     <= rounds_left_d;
			rounds_restore_q  <= rounds_restore_d;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/rtnu_checker.sv
// Port-level checks for the reload timer, bound to the top level.
`default_nettype none
module rtnu_checker
	import rtnu_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_ready,
	input wire logic [1:0]           req_type,
	input wire logic [1:0]           reg_addr,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire logic [DATA_BITS-1:0] read_data,
	input wire logic                 irq_pulse,
	input wire logic                 notify_pulse
);

	logic acc;
	logic ctrl_read;

	assign acc       = req_valid && req_ready;
	assign ctrl_read = acc && (req_type == REQ_READ) && (reg_addr == ADDR_CTRL);

	// ticks, writes and unknown request codes return zero read data
	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type != REQ_READ) |=> (rsp_valid && read_data == '0))
		else $error("non-read beat returned read data");

	// only ticks pulse
	a_pulse_tick_only: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type != REQ_TICK) |=> (!irq_pulse && !notify_pulse))
		else $error("pulse on a non-tick beat");

	// back-to-back control reads: the second sees the flag cleared
	a_flag_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_read ##1 ctrl_read |=> !read_data[CTRL_FLAG_BIT])
		else $error("count flag not cleared by control read");

	// an empty response register never stalls requests
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty response register");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(read_data)
			&& $stable(irq_pulse) && $stable(notify_pulse)))
		else $error("stalled response changed");

endmodule

bind reload_timer_with_round_notify_unit rtnu_checker u_rtnu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_type    (req.req_type),
	.reg_addr    (req.reg_addr),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.read_data   (rsp.read_data),
	.irq_pulse   (rsp.irq_pulse),
	.notify_pulse(rsp.notify_pulse)
);
`default_nettype wire

>>> bench/reload_timer_with_round_notify_unit_tb.sv
// Testbench for the reload timer with round notify: random bus traffic checked against a shadow.
`timescale 1ns / 100ps
module reload_timer_with_round_notify_unit_tb;
	import rtnu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 40;
	localparam int ITEM_COUNT  = 950;
	localparam int CALM_TAIL   = 820;

	// request code with no defined meaning
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// Shadow of the timer state; predicts each response beat and checks it
	class timer_shadow;
		bit                        run_en;
		bit                        irq_en;
		bit                        clk_sel;
		bit                        cnt_flag;
		bit [COUNTER_BITS_DEF-1:0] reload_val;
		bit [COUNTER_BITS_DEF-1:0] cur_val;
		bit                        armed;
		bit                        periodic;
		bit [ROUND_BITS_DEF-1:0]   rounds_left;
		bit [ROUND_BITS_DEF-1:0]   rounds_reload;
		rsp_t                      expected_rsps[$];
		int                        errors;

		function new();
			run_en = 0;
			irq_en = 0;
			clk_sel = 0;
			cnt_flag = 0;
			reload_val = '0;
			cur_val = '0;
			armed = 0;
			periodic = 0;
			rounds_left = '0;
			rounds_reload = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_rsps.size();
		endfunction

		task flag_mismatch(input string what);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		// Advance the shadow by one accepted request beat
		function void note_request(input logic [1:0] kind, input logic [1:0] addr,
				input logic [DATA_BITS-1:0] data);
			rsp_t exp_rsp;
			exp_rsp = '0;
			case (kind)
				REQ_TICK: begin
					if (run_en) begin
						if (cur_val == 0) begin
							cur_val = reload_val;
						end else begin
							cur_val = cur_val - 1'b1;
							// wrap to zero
							if (cur_val == 0) begin
								cnt_flag = 1;
								exp_rsp.irq_pulse = irq_en;
								if (armed) begin
									if (rounds_left != 0) begin
										rounds_left = rounds_left - 1'b1;
									end else begin
										exp_rsp.notify_pulse = 1'b1;
										if (!periodic) begin
											reload_val = '0;
											cur_val = '0;
											armed = 0;
										end else begin
											rounds_left = rounds_reload;
										end
									end
								end
							end
						end
					end
				end
				REQ_READ: begin
					case (addr)
						ADDR_CTRL: begin
							exp_rsp.read_data[CTRL_EN_BIT] = run_en;
							exp_rsp.read_data[CTRL_IRQ_BIT] = irq_en;
							exp_rsp.read_data[CTRL_CLKSRC_BIT] = clk_sel;
							exp_rsp.read_data[CTRL_FLAG_BIT] = cnt_flag;
							cnt_flag = 0;
						end
						ADDR_RELOAD: exp_rsp.read_data[COUNTER_BITS_DEF-1:0] = reload_val;
						ADDR_CURRENT: exp_rsp.read_data[COUNTER_BITS_DEF-1:0] = cur_val;
						default: begin
							exp_rsp.read_data[ROUND_BITS_DEF-1:0] = rounds_left;
							exp_rsp.read_data[ROUND_BITS_DEF] = periodic;
							exp_rsp.read_data[ROUND_BITS_DEF+1] = armed;
						end
					endcase
				end
				REQ_WRITE: begin
					case (addr)
						ADDR_CTRL: begin
							run_en = data[CTRL_EN_BIT];
							irq_en = data[CTRL_IRQ_BIT];
							clk_sel = data[CTRL_CLKSRC_BIT];
						end
						ADDR_RELOAD: reload_val = data[COUNTER_BITS_DEF-1:0];
						ADDR_CURRENT: begin
							cur_val = '0;
							cnt_flag = 0;
						end
						default: begin
							rounds_left = data[ROUND_BITS_DEF-1:0];
							rounds_reload = data[ROUND_BITS_DEF-1:0];
							periodic = data[ROUND_BITS_DEF];
							armed = data[ROUND_BITS_DEF+1];
						end
					endcase
				end
				default: ;  // unknown request: no effect, all-zero response
			endcase
			expected_rsps.push_back(exp_rsp);
		endfunction

		// Compare one response beat with the oldest prediction
		task check_response(input logic [DATA_BITS-1:0] rd, input logic irq,
				input logic notify);
			rsp_t exp_rsp;
			if (expected_rsps.size() == 0) begin
				flag_mismatch("response beat with no request outstanding");
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rd !== exp_rsp.read_data)
					flag_mismatch($sformatf("read_data %h, expected %h", rd, exp_rsp.read_data));
				if (irq !== exp_rsp.irq_pulse)
					flag_mismatch($sformatf("irq_pulse %b, expected %b", irq, exp_rsp.irq_pulse));
				if (notify !== exp_rsp.notify_pulse)
					flag_mismatch($sformatf("notify_pulse %b, expected %b", notify,
						exp_rsp.notify_pulse));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int          cycle_count = 0;
	int          issued = 0;
	bit          idling = 1'b1;
	bit          hold_request = 1'b0;
	timer_shadow shadow;

	rtnu_req_if req_bus();
	rtnu_rsp_if rsp_bus();

	reload_timer_with_round_notify_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Response checking at the rising edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
			shadow.check_response(rsp_bus.read_data, rsp_bus.irq_pulse, rsp_bus.notify_pulse);
	end

	// Response side: random stall bursts, plus one long hold-off on request
	initial begin
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				rsp_bus.ready <= 1'b1;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				rsp_bus.ready <= 1'b1;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// Offer one request beat, starting and ending at a falling edge
	task automatic issue(input logic [1:0] kind, input logic [1:0] addr,
			input logic [DATA_BITS-1:0] data);
		if (idling && $urandom_range(0, 6) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.req_type <= kind;
		req_bus.reg_addr <= addr;
		req_bus.write_data <= data;
		@(posedge clk);
		while (req_bus.ready !== 1'b1) @(posedge clk);
		shadow.note_request(kind, addr, data);
		issued++;
		@(negedge clk);
	endtask

	initial begin
		logic [DATA_BITS-1:0] d;
		int                   pick;
		bit                   hold_done;
		hold_done = 1'b0;
		shadow = new();
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_TICK;
		req_bus.reg_addr = ADDR_CTRL;
		req_bus.write_data = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset values, masking, reload of zero, wrap, flag clear, notify
		issue(REQ_READ, ADDR_CTRL, '0);
		issue(REQ_READ, ADDR_RELOAD, '0);
		issue(REQ_READ, ADDR_CURRENT, '0);
		issue(REQ_READ, ADDR_NOTIFY, '0);
		issue(REQ_WRITE, ADDR_CTRL, '1);
		issue(REQ_WRITE, ADDR_RELOAD, '1);
		issue(REQ_READ, ADDR_RELOAD, '0);
		issue(REQ_WRITE, ADDR_NOTIFY, '1);
		issue(REQ_WRITE, ADDR_RELOAD, '0);
		issue(REQ_TICK, ADDR_CTRL, '0);
		issue(REQ_READ, ADDR_CURRENT, '0);
		issue(REQ_WRITE, ADDR_RELOAD, 32'd1);
		issue(REQ_TICK, ADDR_NOTIFY, '1);
		issue(REQ_WRITE, ADDR_CURRENT, '1);
		issue(REQ_READ, ADDR_CURRENT, '0);
		issue(REQ_TICK, ADDR_CTRL, '0);
		issue(REQ_TICK, ADDR_CTRL, '0);
		issue(REQ_READ, ADDR_CTRL, '0);
		issue(REQ_READ, ADDR_CTRL, '0);
		d = '0;
		d[ROUND_BITS_DEF+1] = 1'b1;  // armed, single mode, no extra rounds
		issue(REQ_WRITE, ADDR_NOTIFY, d);
		issue(REQ_TICK, ADDR_CTRL, '0);
		issue(REQ_TICK, ADDR_CTRL, '0);
		issue(REQ_READ, ADDR_RELOAD, '0);
		issue(REQ_WRITE, ADDR_CTRL, '0);
		issue(REQ_TICK, ADDR_CTRL, '0);
		issue(REQ_UNKNOWN, ADDR_NOTIFY, '1);

		// Random: mostly set-up sequences followed by tick runs, some noise
		while (issued < ITEM_COUNT) begin
			idling = (issued < CALM_TAIL) && ($urandom_range(0, 3) != 0);
			if (!hold_done && issued > 300) begin
				hold_done = 1'b1;
				hold_request = 1'b1;
				idling = 1'b0;
			end
			if ($urandom_range(0, 4) != 0) begin
				d = $urandom;
				if ($urandom_range(0, 7) != 0)
					d[CTRL_EN_BIT] = 1'b1;
				issue(REQ_WRITE, ADDR_CTRL, d);
				if ($urandom_range(0, 15) == 0)
					d = $urandom;
				else
					d = ($urandom & 32'hFF00_0000) | $urandom_range(0, 6);
				issue(REQ_WRITE, ADDR_RELOAD, d);
				if ($urandom_range(0, 2) == 0)
					issue(REQ_WRITE, ADDR_CURRENT, $urandom);
				d = $urandom;
				d[ROUND_BITS_DEF-1:0] = ROUND_BITS_DEF'($urandom_range(0, 3));
				d[ROUND_BITS_DEF+1] = ($urandom_range(0, 3) != 0);
				issue(REQ_WRITE, ADDR_NOTIFY, d);
				repeat ($urandom_range(8, 40)) begin
					pick = $urandom_range(0, 19);
					if (pick < 16)
						issue(REQ_TICK, 2'($urandom_range(0, 3)), $urandom);
					else if (pick < 19)
						issue(REQ_READ, 2'($urandom_range(0, 3)), $urandom);
					else
						issue(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
				end
			end else begin
				repeat ($urandom_range(1, 8))
					issue(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom);
			end
		end

		// Drain and decide
		req_bus.valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (shadow.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> reload_timer_with_round_notify_unit.f
hw/rtl/rtnu_pkg.sv
hw/rtl/rtnu_if.sv
hw/rtl/rtnu_core.sv
hw/rtl/reload_timer_with_round_notify_unit.sv
hw/rtl/rtnu_checker.sv
bench/reload_timer_with_round_notify_unit_tb.sv
